FILE: hdl/cft_pkg.sv
// Shared types and constants for the coordinate frame transform.
package cft_pkg;

   // Width of every point, result and origin field on the ports
   localparam int POINT_W = 32;
   // Width of the plane tolerance register
   localparam int TOL_W = 31;
   // Width of the register index on the write port
   localparam int REG_INDEX_W = 3;

   // Command codes as they arrive on the request channel
   typedef enum logic [1:0] {
      CMD_TO_GLOBAL   = 2'd0,
      CMD_TO_LOCAL    = 2'd1,
      CMD_TO_LOCAL_2D = 2'd2
   } command_type;

   // Operation after classification (unused command folds into 2D)
   typedef enum logic [1:0] {
      OP_GLOBAL   = 2'b01,
      OP_LOCAL    = 2'b10,
      OP_LOCAL_2D = 2'b11
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SINGULAR  = 2'd1,
      STATUS_OUTSIDE   = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   // Register indexes on the write port
   typedef enum logic [REG_INDEX_W-1:0] {
      REG_BASIS_U     = 3'd0,
      REG_BASIS_V     = 3'd1,
      REG_BASIS_W     = 3'd2,
      REG_ORIGIN_X    = 3'd3,
      REG_ORIGIN_Y    = 3'd4,
      REG_ORIGIN_Z    = 3'd5,
      REG_PLANE_TOL   = 3'd6,
      REG_TOL_ENABLE  = 3'd7
   } reg_index_type;

   // Plane check setup handed to the back end
   typedef struct packed {
      logic             enable;
      logic [TOL_W-1:0] limit;
   } plane_cfg_type;

endpackage

FILE: hdl/cft_frame_regs.sv
// Frame registers plus the cofactor and determinant of the basis derived from them.
module cft_frame_regs import cft_pkg::*; #(
   parameter int COORD_WIDTH       = 32,
   parameter int BASIS_ENTRY_WIDTH = 20,
   parameter int CSR_W             = 60
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [REG_INDEX_W-1:0]                csr_index,
   input  logic [CSR_W-1:0]                      csr_wdata,
   output logic signed [BASIS_ENTRY_WIDTH-1:0]   basis_entry [3][3],
   output logic signed [COORD_WIDTH-1:0]         origin [3],
   output plane_cfg_type                         plane_cfg,
   output logic signed [2*BASIS_ENTRY_WIDTH:0]   cofactor [3][3],
   output logic                                  det_neg,
   output logic [3*BASIS_ENTRY_WIDTH+2:0]        det_mag,
   output logic                                  det_zero
);

   localparam int BW    = BASIS_ENTRY_WIDTH;
   localparam int BF    = BW - 4;
   localparam int BB    = 3 * BW;
   localparam int CFW   = 2 * BW + 1;
   localparam int DETW  = 3 * BW + 3;
   localparam logic [BB-1:0] ONE_U = BB'(1) << BF;
   localparam logic signed [CFW-1:0]  COF_ONE = CFW'(1) <<< (2 * BF);
   localparam logic signed [DETW-1:0] DET_ONE = DETW'(1) <<< (3 * BF);

   logic [BB-1:0]      basis_ff [3];
   logic [BB-1:0]      basis_in [3];
   logic [POINT_W-1:0] origin_ff [3];
   logic [POINT_W-1:0] origin_in [3];
   plane_cfg_type      plane_ff;
   plane_cfg_type      plane_in;

   logic signed [CFW-1:0]  cof_ff [3][3];
   logic signed [CFW-1:0]  cof_in [3][3];
   logic signed [DETW-1:0] det_ff;
   logic signed [DETW-1:0] det_in;
   logic [DETW-1:0]        dmag_ff;
   logic [DETW-1:0]        dmag_in;
   logic                   dzero_ff;
   logic                   dzero_in;

   // Register write decode
   always_comb begin
      basis_in  = basis_ff;
      origin_in = origin_ff;
      plane_in  = plane_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_BASIS_U:    basis_in[0] = csr_wdata[BB-1:0];
            REG_BASIS_V:    basis_in[1] = csr_wdata[BB-1:0];
            REG_BASIS_W:    basis_in[2] = csr_wdata[BB-1:0];
            REG_ORIGIN_X:   origin_in[0] = csr_wdata[POINT_W-1:0];
            REG_ORIGIN_Y:   origin_in[1] = csr_wdata[POINT_W-1:0];
            REG_ORIGIN_Z:   origin_in[2] = csr_wdata[POINT_W-1:0];
            REG_PLANE_TOL:  plane_in.limit = csr_wdata[TOL_W-1:0];
            REG_TOL_ENABLE: plane_in.enable = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         basis_ff[0]  <= ONE_U;
         basis_ff[1]  <= ONE_U << BW;
         basis_ff[2]  <= ONE_U << (2 * BW);
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         plane_ff     <= '0;
      end else begin
         basis_ff  <= basis_in;
         origin_ff <= origin_in;
         plane_ff  <= plane_in;
      end
   end

   // Entry view: row r of column k; origin bits are taken as a COORD_WIDTH-bit word
   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar k = 0; k < 3; k++) begin : g_col
         assign basis_entry[r][k] = $signed(basis_ff[k][r*BW +: BW]);
      end
      assign origin[r] = COORD_WIDTH'(origin_ff[r]);
   end
   assign plane_cfg = plane_ff;

   // Signed cofactors, cyclic form of the 2x2 minors
   for (genvar r = 0; r < 3; r++) begin : g_cof_r
      for (genvar k = 0; k < 3; k++) begin : g_cof_k
         localparam int R1 = (r + 1) % 3;
         localparam int R2 = (r + 2) % 3;
         localparam int K1 = (k + 1) % 3;
         localparam int K2 = (k + 2) % 3;
         logic signed [2*BW-1:0] m0;
         logic signed [2*BW-1:0] m1;
         assign m0 = basis_entry[R1][K1] * basis_entry[R2][K2];
         assign m1 = basis_entry[R1][K2] * basis_entry[R2][K1];
         assign cof_in[r][k] = CFW'(m0) - CFW'(m1);
      end
   end

   // Determinant by expansion down the first column
   logic signed [DETW-2:0] dprod [3];
   for (genvar r = 0; r < 3; r++) begin : g_det
      assign dprod[r] = basis_entry[r][0] * cof_ff[r][0];
   end
   assign det_in   = DETW'(dprod[0]) + DETW'(dprod[1]) + DETW'(dprod[2]);
   assign dmag_in  = det_ff[DETW-1] ? DETW'(-det_ff) : DETW'(det_ff);
   assign dzero_in = (det_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               cof_ff[r][k] <= (r == k) ? COF_ONE : '0;
            end
         end
         det_ff   <= DET_ONE;
         dmag_ff  <= DETW'(DET_ONE);
         dzero_ff <= 1'b0;
      end else begin
         cof_ff   <= cof_in;
         det_ff   <= det_in;
         dmag_ff  <= dmag_in;
         dzero_ff <= dzero_in;
      end
   end

   assign cofactor = cof_ff;
   assign det_neg  = det_ff[DETW-1];
   assign det_mag  = dmag_ff;
   assign det_zero = dzero_ff;

endmodule

FILE: hdl/cft_front.sv
// Front end: takes requests, classifies the command, forms the operand and queues it.
module cft_front import cft_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic signed [POINT_W-1:0]     req_point_a,
   input  logic signed [POINT_W-1:0]     req_point_b,
   input  logic signed [POINT_W-1:0]     req_point_c,
   input  logic signed [COORD_WIDTH-1:0] origin [3],
   input  logic                          pop,
   output logic                          head_valid,
   output op_type                        head_op,
   output logic signed [COORD_WIDTH:0]   head_value [3]
);

   localparam int VW     = COORD_WIDTH + 1;
   localparam int DEPTH  = 4;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = PTR_W + 1;

   op_type                 op_in;
   logic signed [VW-1:0]   value_in [3];
   logic signed [VW-1:0]   pt [3];
   logic                   push;

   op_type                 fifo_op_ff    [DEPTH];
   logic signed [VW-1:0]   fifo_value_ff [DEPTH][3];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   // Classify command; the unused code behaves as 2D
   always_comb begin
      case (command_type'(req_command))
         CMD_TO_GLOBAL: op_in = OP_GLOBAL;
         CMD_TO_LOCAL:  op_in = OP_LOCAL;
         default:       op_in = OP_LOCAL_2D;
      endcase
   end

   // Operand: the point itself for to-global, point minus origin otherwise
   assign pt[0] = VW'($signed(COORD_WIDTH'($unsigned(req_point_a))));
   assign pt[1] = VW'($signed(COORD_WIDTH'($unsigned(req_point_b))));
   assign pt[2] = VW'($signed(COORD_WIDTH'($unsigned(req_point_c))));
   for (genvar r = 0; r < 3; r++) begin : g_val
      assign value_in[r] = (op_in == OP_GLOBAL) ? pt[r] : pt[r] - VW'(origin[r]);
   end

   // Queue control
   assign req_stall = (count_ff == CNT_W'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_op_ff[wr_ptr_ff]    <= op_in;
         fifo_value_ff[wr_ptr_ff] <= value_in;
      end
   end

   assign head_op    = fifo_op_ff[rd_ptr_ff];
   assign head_value = fifo_value_ff[rd_ptr_ff];

   // Fill level moves by at most one entry per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1))
               || (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("queue fill level jumped");

   // Nothing is popped from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

   // A full queue holds off the request channel
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(DEPTH)) |-> req_stall)
      else $error("full queue without request stall");

endmodule

FILE: hdl/cft_back.sv
// Back end: multiply, sum, pipelined Cramer division, saturation and status.
module cft_back import cft_pkg::*; #(
   parameter int COORD_WIDTH       = 32,
   parameter int BASIS_ENTRY_WIDTH = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  head_valid,
   input  op_type                                head_op,
   input  logic signed [COORD_WIDTH:0]           head_value [3],
   output logic                                  pop,
   input  logic signed [BASIS_ENTRY_WIDTH-1:0]   basis_entry [3][3],
   input  logic signed [COORD_WIDTH-1:0]         origin [3],
   input  plane_cfg_type                         plane_cfg,
   input  logic signed [2*BASIS_ENTRY_WIDTH:0]   cofactor [3][3],
   input  logic                                  det_neg,
   input  logic [3*BASIS_ENTRY_WIDTH+2:0]        det_mag,
   input  logic                                  det_zero,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [POINT_W-1:0]                    rsp_result_a,
   output logic [POINT_W-1:0]                    rsp_result_b,
   output logic [POINT_W-1:0]                    rsp_result_c,
   output logic [1:0]                            rsp_status
);

   localparam int CW   = COORD_WIDTH;
   localparam int BW   = BASIS_ENTRY_WIDTH;
   localparam int BF   = BW - 4;
   localparam int CFW  = 2 * BW + 1;
   localparam int DETW = 3 * BW + 3;
   localparam int LO   = BW;
   localparam int HIW  = CFW - LO;
   localparam int VW   = CW + 1;
   localparam int LPW  = VW + HIW;
   localparam int NUMW = CW + 2 * BW + 4;
   localparam int NMW  = NUMW + BF;
   localparam int QW   = (CW > POINT_W) ? CW : POINT_W;
   localparam int RW   = (NMW > DETW + QW) ? NMW : DETW + QW;
   localparam int GPW  = VW + BW;
   localparam int GW   = GPW + 2;
   localparam int SW   = GW + 1;

   localparam logic signed [GW-1:0] BF_ROUND = (GW'(1) <<< BF) - GW'(1);
   localparam logic signed [GW-1:0] G_ZERO   = '0;
   localparam logic signed [SW-1:0] G_MAX    = (SW'(1) <<< (CW - 1)) - SW'(1);
   localparam logic signed [SW-1:0] G_MIN    = -(SW'(1) <<< (CW - 1));
   localparam logic signed [CW-1:0] C_MAX    = CW'(G_MAX);
   localparam logic signed [CW-1:0] C_MIN    = CW'(G_MIN);
   localparam logic [QW-1:0]        Q_MAXP   = QW'((64'd1 << (CW - 1)) - 64'd1);
   localparam logic [QW-1:0]        Q_MAXN   = QW'(64'd1 << (CW - 1));

   logic advance;
   assign advance = !rsp_valid || !rsp_stall;
   assign pop     = head_valid && advance;

   // ---------------- stage 1: operand capture ----------------
   logic                 s1_valid_ff;
   op_type               s1_op_ff;
   logic signed [VW-1:0] s1_val_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= head_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff  <= head_op;
         s1_val_ff <= head_value;
      end
   end

   // ---------------- stage 2: products ----------------
   logic                  s2_valid_ff;
   op_type                s2_op_ff;
   logic signed [GPW-1:0] s2_gprod_ff [3][3];
   logic signed [GPW-1:0] s2_gprod_in [3][3];
   logic signed [LPW-1:0] s2_lphi_ff [3][3];
   logic signed [LPW-1:0] s2_lphi_in [3][3];
   logic signed [LPW-1:0] s2_lplo_ff [3][3];
   logic signed [LPW-1:0] s2_lplo_in [3][3];

   // gprod[k][r]: point k times basis row r of column k; lp*[r][k]: operand r times cofactor
   for (genvar a = 0; a < 3; a++) begin : g_mul_a
      for (genvar b = 0; b < 3; b++) begin : g_mul_b
         assign s2_gprod_in[a][b] = s1_val_ff[a] * basis_entry[b][a];
         assign s2_lphi_in[a][b]  = s1_val_ff[a] * $signed(cofactor[a][b][CFW-1:LO]);
         assign s2_lplo_in[a][b]  = s1_val_ff[a] * $signed({1'b0, cofactor[a][b][LO-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_op_ff    <= s1_op_ff;
         s2_gprod_ff <= s2_gprod_in;
         s2_lphi_ff  <= s2_lphi_in;
         s2_lplo_ff  <= s2_lplo_in;
      end
   end

   // ---------------- stage 3: sums ----------------
   logic                  s3_valid_ff;
   op_type                s3_op_ff;
   logic [POINT_W-1:0]    s3_glob_ff [3];
   logic [POINT_W-1:0]    s3_glob_in [3];
   logic [2:0]            s3_gsat_in;
   logic                  s3_gsat_ff;
   logic [NMW-1:0]        s3_nm_ff [3];
   logic [NMW-1:0]        s3_nm_in [3];
   logic [2:0]            s3_neg_ff;
   logic [2:0]            s3_neg_in;

   for (genvar r = 0; r < 3; r++) begin : g_glob
      logic signed [GW-1:0] acc;
      logic signed [GW-1:0] tr;
      logic signed [SW-1:0] sum;
      logic signed [CW-1:0] clamped;
      logic                 sat_r;
      // Matrix row, truncate toward zero, then add origin and clamp
      assign acc = GW'(s2_gprod_ff[0][r]) + GW'(s2_gprod_ff[1][r]) + GW'(s2_gprod_ff[2][r]);
      assign tr  = (acc + (acc[GW-1] ? BF_ROUND : G_ZERO)) >>> BF;
      assign sum = SW'(tr) + SW'(origin[r]);
      always_comb begin
         sat_r   = 1'b0;
         clamped = CW'(sum);
         if (sum > G_MAX) begin
            sat_r   = 1'b1;
            clamped = C_MAX;
         end else if (sum < G_MIN) begin
            sat_r   = 1'b1;
            clamped = C_MIN;
         end
      end
      assign s3_gsat_in[r] = sat_r;
      assign s3_glob_in[r] = POINT_W'(clamped);
   end

   for (genvar k = 0; k < 3; k++) begin : g_num
      logic signed [NUMW-1:0] num;
      logic [NUMW-1:0]        mag;
      // Cramer numerator: operand vector against cofactor column k
      assign num = (NUMW'(s2_lphi_ff[0][k]) <<< LO) + NUMW'(s2_lplo_ff[0][k])
                 + (NUMW'(s2_lphi_ff[1][k]) <<< LO) + NUMW'(s2_lplo_ff[1][k])
                 + (NUMW'(s2_lphi_ff[2][k]) <<< LO) + NUMW'(s2_lplo_ff[2][k]);
      assign mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
      assign s3_nm_in[k]  = NMW'(mag) << BF;
      assign s3_neg_in[k] = num[NUMW-1] ^ det_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_op_ff   <= s2_op_ff;
         s3_glob_ff <= s3_glob_in;
         s3_gsat_ff <= |s3_gsat_in;
         s3_nm_ff   <= s3_nm_in;
         s3_neg_ff  <= s3_neg_in;
      end
   end

   // ---------------- division pipeline: one quotient bit per stage ----------------
   logic               d_valid_ff [QW+1];
   op_type             d_op_ff    [QW+1];
   logic [POINT_W-1:0] d_glob_ff  [QW+1][3];
   logic               d_gsat_ff  [QW+1];
   logic [2:0]         d_neg_ff   [QW+1];
   logic [2:0]         d_big_ff   [QW+1];
   logic [RW-1:0]      d_rem_ff   [QW+1][3];
   logic [RW-1:0]      d_rem_in   [QW+1][3];
   logic [QW-1:0]      d_q_ff     [QW+1][3];
   logic [QW-1:0]      d_q_in     [QW+1][3];
   logic [2:0]         d_big_in;

   // Entry stage: quotient at or above 2^QW is flagged as out of range
   for (genvar k = 0; k < 3; k++) begin : g_d0
      assign d_rem_in[0][k] = RW'(s3_nm_ff[k]);
      assign d_q_in[0][k]   = '0;
      assign d_big_in[k]    = RW'(s3_nm_ff[k]) >= (RW'(det_mag) << QW);
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int BIT = QW - 1 - j;
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic [RW-1:0] sub;
         logic          take;
         assign sub  = RW'(det_mag) << BIT;
         assign take = d_rem_ff[j][k] >= sub;
         assign d_rem_in[j+1][k] = take ? d_rem_ff[j][k] - sub : d_rem_ff[j][k];
         assign d_q_in[j+1][k]   = {d_q_ff[j][k][QW-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QW; j++) begin
            d_valid_ff[j] <= 1'b0;
         end
      end else if (advance) begin
         d_valid_ff[0] <= s3_valid_ff;
         for (int j = 1; j <= QW; j++) begin
            d_valid_ff[j] <= d_valid_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_op_ff[0]   <= s3_op_ff;
         d_glob_ff[0] <= s3_glob_ff;
         d_gsat_ff[0] <= s3_gsat_ff;
         d_neg_ff[0]  <= s3_neg_ff;
         d_big_ff[0]  <= d_big_in;
         d_rem_ff[0]  <= d_rem_in[0];
         d_q_ff[0]    <= d_q_in[0];
         for (int j = 1; j <= QW; j++) begin
            d_op_ff[j]   <= d_op_ff[j-1];
            d_glob_ff[j] <= d_glob_ff[j-1];
            d_gsat_ff[j] <= d_gsat_ff[j-1];
            d_neg_ff[j]  <= d_neg_ff[j-1];
            d_big_ff[j]  <= d_big_ff[j-1];
            d_rem_ff[j]  <= d_rem_in[j];
            d_q_ff[j]    <= d_q_in[j];
         end
      end
   end

   // ---------------- result stage ----------------
   logic [POINT_W-1:0] loc_val [3];
   logic [2:0]         loc_sat;
   logic               outside;

   for (genvar k = 0; k < 3; k++) begin : g_fin
      logic [QW-1:0]        q;
      logic                 big;
      logic                 neg;
      logic                 sat_k;
      logic signed [CW-1:0] v;
      assign q   = d_q_ff[QW][k];
      assign big = d_big_ff[QW][k];
      assign neg = d_neg_ff[QW][k];
      always_comb begin
         if (neg) begin
            sat_k = big || (q > Q_MAXN);
            v     = sat_k ? C_MIN : $signed(-q[CW-1:0]);
         end else begin
            sat_k = big || (q > Q_MAXP);
            v     = sat_k ? C_MAX : $signed(q[CW-1:0]);
         end
      end
      assign loc_sat[k] = sat_k;
      assign loc_val[k] = POINT_W'(v);
   end

   // Third coordinate magnitude against the plane limit
   assign outside = plane_cfg.enable
                 && (d_big_ff[QW][2] || (d_q_ff[QW][2] >= QW'(plane_cfg.limit)));

   logic               out_valid_ff, out_valid_in;
   logic [POINT_W-1:0] out_res_ff [3];
   logic [POINT_W-1:0] out_res_in [3];
   status_type         out_status_ff, out_status_in;

   always_comb begin
      out_res_in    = loc_val;
      out_status_in = STATUS_OK;
      case (d_op_ff[QW])
         OP_GLOBAL: begin
            out_res_in    = d_glob_ff[QW];
            out_status_in = d_gsat_ff[QW] ? STATUS_SATURATED : STATUS_OK;
         end
         OP_LOCAL: begin
            out_status_in = (|loc_sat) ? STATUS_SATURATED : STATUS_OK;
         end
         default: begin
            out_res_in[2] = '0;
            if (outside) begin
               out_status_in = STATUS_OUTSIDE;
            end else if (loc_sat[0] || loc_sat[1]) begin
               out_status_in = STATUS_SATURATED;
            end
         end
      endcase
      // Singular basis overrides everything for the solving commands
      if (d_op_ff[QW] != OP_GLOBAL && det_zero) begin
         out_res_in[0] = '0;
         out_res_in[1] = '0;
         out_res_in[2] = '0;
         out_status_in = STATUS_SINGULAR;
      end
   end

   assign out_valid_in = advance ? d_valid_ff[QW] : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff    <= out_res_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_result_a = out_res_ff[0];
   assign rsp_result_b = out_res_ff[1];
   assign rsp_result_c = out_res_ff[2];
   assign rsp_status   = out_status_ff;

   // Singular status only when the frame determinant is zero
   a_singular: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_status_ff == STATUS_SINGULAR) |-> det_zero)
      else $error("singular status with nonzero determinant");

   // Outside-plane status needs the check enabled and a cleared third result
   a_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_status_ff == STATUS_OUTSIDE) |-> plane_cfg.enable && (out_res_ff[2] == '0))
      else $error("outside status without enabled plane check");

   // A held result does not let the pipeline move underneath it
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(out_status_ff) && $stable(d_valid_ff[QW]))
      else $error("pipeline advanced while result stalled");

endmodule

FILE: hdl/coordinate_frame_transform.sv
// Top level of the coordinate frame transform: front end, frame registers, back end.
//
//  channel   direction  handshake          payload
//  req       in         req_valid/stall    command, point_a/b/c
//  rsp       out        rsp_valid/stall    result_a/b/c, status
//  csr       in         csr_wr_en          csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall is low. The restoring divider retires one
// quotient bit per stage for each of the three Cramer quotients, which are QW bits wide,
// with QW = max(COORD_WIDTH, 32).
// A four-entry queue sits between front and back; req_stall rises only when it is full.
// Reset is synchronous and loads the identity basis, zero origin and a disabled plane check.
// A stalled result freezes the back end; the front keeps filling the queue meanwhile.
module coordinate_frame_transform import cft_pkg::*; #(
   parameter int COORD_WIDTH       = 32,
   parameter int BASIS_ENTRY_WIDTH = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_command,
   input  logic signed [POINT_W-1:0]        req_point_a,
   input  logic signed [POINT_W-1:0]        req_point_b,
   input  logic signed [POINT_W-1:0]        req_point_c,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [POINT_W-1:0]        rsp_result_a,
   output logic signed [POINT_W-1:0]        rsp_result_b,
   output logic signed [POINT_W-1:0]        rsp_result_c,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_wr_en,
   input  logic [REG_INDEX_W-1:0]           csr_index,
   input  logic [((3*BASIS_ENTRY_WIDTH > POINT_W) ? 3*BASIS_ENTRY_WIDTH : POINT_W)-1:0]
                                            csr_wdata
);

   localparam int BW    = BASIS_ENTRY_WIDTH;
   localparam int CSR_W = (3 * BW > POINT_W) ? 3 * BW : POINT_W;

   logic signed [BW-1:0]          basis_entry [3][3];
   logic signed [COORD_WIDTH-1:0] origin [3];
   plane_cfg_type                 plane_cfg;
   logic signed [2*BW:0]          cofactor [3][3];
   logic                          det_neg;
   logic [3*BW+2:0]               det_mag;
   logic                          det_zero;

   logic                          head_valid;
   op_type                        head_op;
   logic signed [COORD_WIDTH:0]   head_value [3];
   logic                          pop;
   logic [POINT_W-1:0]            res_a, res_b, res_c;

   cft_frame_regs #(
      .COORD_WIDTH       (COORD_WIDTH),
      .BASIS_ENTRY_WIDTH (BW),
      .CSR_W             (CSR_W)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .basis_entry (basis_entry),
      .origin      (origin),
      .plane_cfg   (plane_cfg),
      .cofactor    (cofactor),
      .det_neg     (det_neg),
      .det_mag     (det_mag),
      .det_zero    (det_zero)
   );

   cft_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_point_a (req_point_a),
      .req_point_b (req_point_b),
      .req_point_c (req_point_c),
      .origin      (origin),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_op     (head_op),
      .head_value  (head_value)
   );

   cft_back #(
      .COORD_WIDTH       (COORD_WIDTH),
      .BASIS_ENTRY_WIDTH (BW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_op      (head_op),
      .head_value   (head_value),
      .pop          (pop),
      .basis_entry  (basis_entry),
      .origin       (origin),
      .plane_cfg    (plane_cfg),
      .cofactor     (cofactor),
      .det_neg      (det_neg),
      .det_mag      (det_mag),
      .det_zero     (det_zero),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result_a (res_a),
      .rsp_result_b (res_b),
      .rsp_result_c (res_c),
      .rsp_status   (rsp_status)
   );

   assign rsp_result_a = $signed(res_a);
   assign rsp_result_b = $signed(res_b);
   assign rsp_result_c = $signed(res_c);

endmodule

FILE: tb/coordinate_frame_transform_checker.sv
// Checker for the coordinate frame transform: frame register mirror, predictor and compare.
module coordinate_frame_transform_checker import cft_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_command,
   input  logic signed [POINT_W-1:0]   req_point_a,
   input  logic signed [POINT_W-1:0]   req_point_b,
   input  logic signed [POINT_W-1:0]   req_point_c,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [POINT_W-1:0]   rsp_result_a,
   input  logic signed [POINT_W-1:0]   rsp_result_b,
   input  logic signed [POINT_W-1:0]   rsp_result_c,
   input  logic [1:0]                  rsp_status,
   input  logic                        csr_wr_en,
   input  logic [REG_INDEX_W-1:0]      csr_index,
   input  logic [59:0]                 csr_wdata,
   output int                          fail_count,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EW = 20;
   localparam int FR = 16;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic [1:0]         st;
   } point_result_type;

   // Mirror of the frame registers
   logic [59:0]        frame_u, frame_v, frame_w;
   logic signed [31:0] frame_org [3];
   logic [30:0]        plane_limit;
   logic               plane_on;

   point_result_type expected_results [$];

   function automatic logic signed [127:0] entry_of(logic [59:0] col, int r);
      logic signed [19:0] e;
      e = col[r*EW +: EW];
      return 128'(e);
   endfunction

   function automatic logic signed [127:0] det_of(logic signed [127:0] m [3][3]);
      // m[col][row]
      return m[0][0]*m[1][1]*m[2][2] + m[0][2]*m[1][0]*m[2][1] + m[0][1]*m[1][2]*m[2][0]
           - m[0][2]*m[1][1]*m[2][0] - m[0][0]*m[1][2]*m[2][1] - m[0][1]*m[1][0]*m[2][2];
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [127:0] v, ref logic sat);
      if (v > 128'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Predict the result for one transfer
   function automatic point_result_type transform_point(logic [1:0] cmd,
         logic signed [31:0] pa, logic signed [31:0] pb, logic signed [31:0] pc);
      logic signed [127:0] m [3][3];
      logic signed [127:0] n [3][3];
      logic signed [127:0] p [3];
      logic signed [127:0] acc, d, num, q, mag;
      logic [127:0] dmag;
      logic sat, outside;
      logic signed [31:0] res [3];
      point_result_type r;
      sat = 1'b0;
      outside = 1'b0;
      p[0] = 128'(pa);
      p[1] = 128'(pb);
      p[2] = 128'(pc);
      for (int r2 = 0; r2 < 3; r2++) begin
         m[0][r2] = entry_of(frame_u, r2);
         m[1][r2] = entry_of(frame_v, r2);
         m[2][r2] = entry_of(frame_w, r2);
      end
      if (cmd == CMD_TO_GLOBAL) begin
         for (int r2 = 0; r2 < 3; r2++) begin
            acc = p[0]*m[0][r2] + p[1]*m[1][r2] + p[2]*m[2][r2];
            mag = acc < 0 ? -acc : acc;
            mag = mag >>> FR;
            acc = (acc < 0 ? -mag : mag) + 128'(frame_org[r2]);
            res[r2] = clamp32(acc, sat);
         end
         r.a = res[0];
         r.b = res[1];
         r.c = res[2];
         r.st = sat ? STATUS_SATURATED : STATUS_OK;
         return r;
      end
      for (int r2 = 0; r2 < 3; r2++) p[r2] = p[r2] - 128'(frame_org[r2]);
      d = det_of(m);
      if (d == 0) begin
         r = '0;
         r.st = STATUS_SINGULAR;
         return r;
      end
      dmag = d < 0 ? -d : d;
      for (int k = 0; k < 3; k++) begin
         n = m;
         for (int r2 = 0; r2 < 3; r2++) n[k][r2] = p[r2];
         num = det_of(n);
         mag = num < 0 ? -num : num;
         q = (mag <<< FR) / dmag;
         if (k == 2 && cmd != CMD_TO_LOCAL) begin
            if (plane_on && q >= 128'(plane_limit)) outside = 1'b1;
            res[2] = '0;
         end else begin
            res[k] = clamp32(((num < 0) != (d < 0)) ? -q : q, sat);
         end
      end
      r.a = res[0];
      r.b = res[1];
      r.c = res[2];
      r.st = outside ? STATUS_OUTSIDE : (sat ? STATUS_SATURATED : STATUS_OK);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending = expected_results.size();

   always @(posedge clock) begin
      point_result_type e;
      if (reset) begin
         frame_u <= 60'd65536;
         frame_v <= 60'd65536 << EW;
         frame_w <= 60'd65536 << (2*EW);
         frame_org[0] <= '0;
         frame_org[1] <= '0;
         frame_org[2] <= '0;
         plane_limit <= '0;
         plane_on <= 1'b0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         // Register writes
         if (csr_wr_en) begin
            case (reg_index_type'(csr_index))
               REG_BASIS_U: frame_u <= csr_wdata;
               REG_BASIS_V: frame_v <= csr_wdata;
               REG_BASIS_W: frame_w <= csr_wdata;
               REG_ORIGIN_X: frame_org[0] <= csr_wdata[31:0];
               REG_ORIGIN_Y: frame_org[1] <= csr_wdata[31:0];
               REG_ORIGIN_Z: frame_org[2] <= csr_wdata[31:0];
               REG_PLANE_TOL: plane_limit <= csr_wdata[30:0];
               REG_TOL_ENABLE: plane_on <= csr_wdata[0];
               default: ;
            endcase
         end
         // Request transfer
         if (req_valid && !req_stall)
            expected_results.push_back(transform_point(req_command, req_point_a,
                                                       req_point_b, req_point_c));
         // Result transfer
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("unexpected result transfer at %0t", $realtime);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_result_a !== e.a) report_mismatch("result_a", rsp_result_a, e.a);
               if (rsp_result_b !== e.b) report_mismatch("result_b", rsp_result_b, e.b);
               if (rsp_result_c !== e.c) report_mismatch("result_c", rsp_result_c, e.c);
               if (rsp_status !== e.st) report_mismatch("status", 32'(rsp_status), 32'(e.st));
            end
         end
      end
   end
endmodule

FILE: tb/coordinate_frame_transform_test.sv
// Testbench top for the coordinate frame transform: stimulus, register setup and verdict.
module coordinate_frame_transform_test;
   import cft_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = '0;
   logic signed [31:0] req_point_a = '0, req_point_b = '0, req_point_c = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_a, rsp_result_b, rsp_result_c;
   logic [1:0] rsp_status;
   logic csr_wr_en = 1'b0;
   logic [REG_INDEX_W-1:0] csr_index = '0;
   logic [59:0] csr_wdata = '0;
   int fail_count;
   int pending;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit stall_noise = 1'b1;

   coordinate_frame_transform dut (.*);
   coordinate_frame_transform_checker check (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver stall pattern, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (!stall_noise) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [19:0] rand_entry();
      case ($urandom_range(0, 5))
         0: return 20'h10000;
         1: return 20'h80000;
         2: return 20'h7ffff;
         3: return 20'h0;
         4: return 20'($signed(-65536));
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
         default: return $urandom;
      endcase
   endfunction

   // Assert the write enable, then drop it again before returning, so back-to-back writes never collide
   task automatic write_reg(reg_index_type idx, logic [59:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Wait for the block to drain before reprogramming
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   // Offer one point and hold it until transferred
   task automatic send_point(command_type cmd, logic [31:0] a, logic [31:0] b,
                             logic [31:0] c);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_point_a <= a;
      req_point_b <= b;
      req_point_c <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
            burst = $urandom_range(1, 20);
         end
         send_point(command_type'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                    rand_coord());
         burst--;
      end
      req_valid <= 1'b0;
   endtask

   task automatic random_frame();
      write_reg(REG_BASIS_U, {rand_entry(), rand_entry(), rand_entry()});
      write_reg(REG_BASIS_V, {rand_entry(), rand_entry(), rand_entry()});
      write_reg(REG_BASIS_W, {rand_entry(), rand_entry(), rand_entry()});
      write_reg(REG_ORIGIN_X, 60'(rand_coord()));
      write_reg(REG_ORIGIN_Y, 60'(rand_coord()));
      write_reg(REG_ORIGIN_Z, 60'(rand_coord()));
      write_reg(REG_PLANE_TOL, 60'($urandom_range(0, 3) == 0 ? 31'h7fffffff
                                                             : 31'($urandom_range(0, 1 << 20))));
      write_reg(REG_TOL_ENABLE, 60'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: identity frame, every command, field extremes
      send_point(CMD_TO_GLOBAL, 32'h7fffffff, 32'h80000000, 32'h0);
      send_point(CMD_TO_LOCAL, 32'h7fffffff, 32'h80000000, 32'hffffffff);
      send_point(CMD_TO_LOCAL_2D, 32'h00010000, 32'h00020000, 32'h00030000);
      send_point(command_type'(2'd3), 32'h0, 32'h0, 32'h0);
      req_valid <= 1'b0;
      drain();
      // Scaled frame with origin: saturation on the way out
      write_reg(REG_BASIS_U, {20'h0, 20'h0, 20'h7ffff});
      write_reg(REG_ORIGIN_X, 60'h7fffffff);
      write_reg(REG_ORIGIN_Y, 60'h80000000);
      write_reg(REG_PLANE_TOL, 60'h00010000);
      write_reg(REG_TOL_ENABLE, 60'd1);
      send_point(CMD_TO_GLOBAL, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_point(CMD_TO_LOCAL, 32'h80000000, 32'h7fffffff, 32'h0);
      send_point(CMD_TO_LOCAL_2D, 32'h0, 32'h0, 32'h00010000);
      send_point(CMD_TO_LOCAL_2D, 32'h0, 32'h0, 32'h0000ffff);
      send_point(CMD_TO_LOCAL_2D, 32'h0, 32'h0, 32'hffff0000);
      req_valid <= 1'b0;
      drain();
      // Singular basis: u equals zero
      write_reg(REG_BASIS_U, 60'h0);
      send_point(CMD_TO_LOCAL, 32'h00010000, 32'h0, 32'h0);
      send_point(CMD_TO_LOCAL_2D, 32'h00010000, 32'h0, 32'h0);
      send_point(CMD_TO_GLOBAL, 32'h00010000, 32'h0, 32'h0);
      req_valid <= 1'b0;
      drain();
      // Tiny determinant: huge quotients
      write_reg(REG_BASIS_U, 60'h1);
      write_reg(REG_BASIS_V, 60'h1 << 20);
      write_reg(REG_BASIS_W, 60'h1 << 40);
      write_reg(REG_TOL_ENABLE, 60'd0);
      send_point(CMD_TO_LOCAL, 32'h7fffffff, 32'h12345678, 32'h80000000);
      send_point(CMD_TO_LOCAL_2D, 32'h00000001, 32'hffffffff, 32'h7fffffff);
      req_valid <= 1'b0;
      drain();

      // Long receiver hold-off while the sender keeps offering
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         send_random(80);
      join
      drain();

      // Random phases over several frames
      for (int phase = 0; phase < 12; phase++) begin
         random_frame();
         stall_noise = (phase % 4 != 3);
         send_random(100);
         drain();
      end

      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
